// ===== hw/rtl/vcsf_pkg.sv =====
// shared constants, types and state encodings of the voxel cuboid and sphere fill block
// no dependencies; imported by every module of the block
package vcsf_pkg;

  localparam int DEF_MAX_SIZE_X = 16;
  localparam int DEF_MAX_SIZE_Y = 16;
  localparam int DEF_MAX_SIZE_Z = 16;

  localparam int CMD_W  = 2;
  localparam int CRD_W  = 10;
  localparam int RAD_W  = 13;
  localparam int VAL_W  = 8;
  localparam int SIZE_W = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // delta of a voxel to the sphere centre, its square, and the sum of three squares
  localparam int DLT_W = CRD_W + 1;
  localparam int SQ_W  = 20;
  localparam int D2_W  = 22;
  // radius squared over 256
  localparam int R2S_W = 16;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PLACE  = 2'd0,
    CMD_CUBOID = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_SETUP = 3'd2,
    ST_SCAN  = 3'd3,
    ST_READ  = 3'd4,
    ST_DONE  = 3'd5
  } state_t;

  typedef struct packed {
    logic start;
    logic sphere;
  } scan_ctl_t;

endpackage

// ===== hw/rtl/voxel_cuboid_sphere_fill.sv =====
// top level of the voxel cuboid and sphere fill block: command sequencer, clear pass,
// size registers and output register; depends on vcsf_pkg, vcsf_store, vcsf_scan
//
// The block holds a voxel store of bytes in one memory with one write and one read port.
// After reset it runs a clearing pass that writes zero to all 2**(clog2(MAX_SIZE_X) +
// clog2(MAX_SIZE_Y) + clog2(MAX_SIZE_Z)) entries, one per cycle, with in_tready low; size
// writes are taken during it. One command is processed at a time. Fill cuboid visits every
// voxel of the clamped box, and fill sphere visits and tests once every voxel in use,
// each write going through the single write port. A finished result sits in the output
// register, so the next word is taken while it waits.
module voxel_cuboid_sphere_fill #(
  parameter int MAX_SIZE_X = vcsf_pkg::DEF_MAX_SIZE_X,
  parameter int MAX_SIZE_Y = vcsf_pkg::DEF_MAX_SIZE_Y,
  parameter int MAX_SIZE_Z = vcsf_pkg::DEF_MAX_SIZE_Z
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, radius_fixed, block_value
  input  logic [vcsf_pkg::IN_TDATA_W-1:0]      in_tdata,
  // command
  input  logic [vcsf_pkg::CMD_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // read_value, read_hit
  output logic [vcsf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vcsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vcsf_pkg::SIZE_W-1:0]          cfg_data
);
  import vcsf_pkg::*;

  localparam int XW = $clog2(MAX_SIZE_X);
  localparam int YW = $clog2(MAX_SIZE_Y);
  localparam int ZW = $clog2(MAX_SIZE_Z);
  localparam int AW = XW + YW + ZW;
  localparam int RM_W = RAD_W - 1;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;

  cmd_t                    cmd_r;
  logic signed [CRD_W-1:0] fx_r, fy_r, fz_r, sx_r, sy_r, sz_r;
  logic signed [RAD_W-1:0] rad_r;
  logic [VAL_W-1:0]        blk_r;

  logic [AW-1:0]     clr_addr_r;
  logic              clr_we;
  logic              in_acc;

  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic              load_out;
  logic              out_tvalid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_hit_r;

  // effective upper bounds and empty axes
  logic [XW-1:0] hix;
  logic [YW-1:0] hiy;
  logic [ZW-1:0] hiz;
  logic          zx, zy, zz, any_zero;
  logic          in_x, in_y, in_z, in_box;

  // clamped corners
  logic [XW-1:0] cax, cbx;
  logic [YW-1:0] cay, cby;
  logic [ZW-1:0] caz, cbz;

  logic [XW-1:0] lo_x, hi_x;
  logic [YW-1:0] lo_y, hi_y;
  logic [ZW-1:0] lo_z, hi_z;

  logic [RM_W-1:0]   rmag;
  logic [2*RM_W-1:0] r2_full;
  logic [R2S_W-1:0]  r2s;

  scan_ctl_t        scan_ctl;
  logic             scan_done;
  logic             scan_we;
  logic [AW-1:0]    scan_waddr;
  logic [VAL_W-1:0] scan_wdata;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_data;

  // size registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_data;
        REG_SIZE_Y: size_y_r <= cfg_data;
        REG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // command capture
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= cmd_t'(in_tuser);
      fx_r  <= in_tdata[9:0];
      fy_r  <= in_tdata[19:10];
      fz_r  <= in_tdata[29:20];
      sx_r  <= in_tdata[39:30];
      sy_r  <= in_tdata[49:40];
      sz_r  <= in_tdata[59:50];
      rad_r <= in_tdata[72:60];
      blk_r <= in_tdata[80:73];
    end
  end

  // bounds
  assign zx = (size_x_r == '0);
  assign zy = (size_y_r == '0);
  assign zz = (size_z_r == '0);
  assign any_zero = zx || zy || zz;

  assign hix = (int'(size_x_r) >= MAX_SIZE_X) ? XW'(MAX_SIZE_X - 1) : XW'(size_x_r - 5'd1);
  assign hiy = (int'(size_y_r) >= MAX_SIZE_Y) ? YW'(MAX_SIZE_Y - 1) : YW'(size_y_r - 5'd1);
  assign hiz = (int'(size_z_r) >= MAX_SIZE_Z) ? ZW'(MAX_SIZE_Z - 1) : ZW'(size_z_r - 5'd1);

  assign in_x = !zx && !fx_r[CRD_W-1] && ($unsigned(fx_r) <= CRD_W'(hix));
  assign in_y = !zy && !fy_r[CRD_W-1] && ($unsigned(fy_r) <= CRD_W'(hiy));
  assign in_z = !zz && !fz_r[CRD_W-1] && ($unsigned(fz_r) <= CRD_W'(hiz));
  assign in_box = in_x && in_y && in_z;

  assign cax = fx_r[CRD_W-1] ? '0 : (($unsigned(fx_r) > CRD_W'(hix)) ? hix : fx_r[XW-1:0]);
  assign cbx = sx_r[CRD_W-1] ? '0 : (($unsigned(sx_r) > CRD_W'(hix)) ? hix : sx_r[XW-1:0]);
  assign cay = fy_r[CRD_W-1] ? '0 : (($unsigned(fy_r) > CRD_W'(hiy)) ? hiy : fy_r[YW-1:0]);
  assign cby = sy_r[CRD_W-1] ? '0 : (($unsigned(sy_r) > CRD_W'(hiy)) ? hiy : sy_r[YW-1:0]);
  assign caz = fz_r[CRD_W-1] ? '0 : (($unsigned(fz_r) > CRD_W'(hiz)) ? hiz : fz_r[ZW-1:0]);
  assign cbz = sz_r[CRD_W-1] ? '0 : (($unsigned(sz_r) > CRD_W'(hiz)) ? hiz : sz_r[ZW-1:0]);

  always_comb begin
    lo_x = cax;
    hi_x = cax;
    lo_y = cay;
    hi_y = cay;
    lo_z = caz;
    hi_z = caz;
    unique case (cmd_r)
      CMD_CUBOID: begin
        lo_x = (cax < cbx) ? cax : cbx;
        hi_x = (cax < cbx) ? cbx : cax;
        lo_y = (cay < cby) ? cay : cby;
        hi_y = (cay < cby) ? cby : cay;
        lo_z = (caz < cbz) ? caz : cbz;
        hi_z = (caz < cbz) ? cbz : caz;
      end
      CMD_SPHERE: begin
        lo_x = '0;
        hi_x = hix;
        lo_y = '0;
        hi_y = hiy;
        lo_z = '0;
        hi_z = hiz;
      end
      CMD_PLACE, CMD_READ: ;
      default: ;
    endcase
  end

  // radius squared over 256, exact for an integer squared distance
  assign rmag    = rad_r[RM_W-1:0];
  assign r2_full = rmag * rmag;
  assign r2s     = r2_full[2*RM_W-1 -: R2S_W];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    scan_ctl      = '0;
    rd_en         = 1'b0;
    clr_we        = 1'b0;
    load_out      = 1'b0;
    res_value_nxt = res_value_r;
    res_hit_nxt   = res_hit_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        res_value_nxt = '0;
        res_hit_nxt   = 1'b0;
        state_nxt     = ST_DONE;
        unique case (cmd_r)
          CMD_READ: begin
            if (in_box) begin
              rd_en     = 1'b1;
              state_nxt = ST_READ;
            end
          end
          CMD_PLACE: begin
            if (in_box) begin
              scan_ctl.start = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end
          CMD_CUBOID: begin
            if (!any_zero) begin
              scan_ctl.start = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end
          CMD_SPHERE: begin
            if (!any_zero && !rad_r[RAD_W-1]) begin
              scan_ctl.start  = 1'b1;
              scan_ctl.sphere = 1'b1;
              state_nxt       = ST_SCAN;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        res_value_nxt = rd_data;
        res_hit_nxt   = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_we) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_value_r <= res_value_nxt;
    res_hit_r   <= res_hit_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r <= res_value_r;
      out_hit_r   <= res_hit_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-VAL_W-1){1'b0}}, out_hit_r, out_value_r};

  // memory ports
  assign mem_we    = clr_we || scan_we;
  assign mem_waddr = clr_we ? clr_addr_r : scan_waddr;
  assign mem_wdata = clr_we ? '0 : scan_wdata;
  assign rd_addr   = {fx_r[XW-1:0], fy_r[YW-1:0], fz_r[ZW-1:0]};

  vcsf_scan #(
    .XW(XW),
    .YW(YW),
    .ZW(ZW)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .lo_x  (lo_x),
    .hi_x  (hi_x),
    .lo_y  (lo_y),
    .hi_y  (hi_y),
    .lo_z  (lo_z),
    .hi_z  (hi_z),
    .ctr_x (fx_r),
    .ctr_y (fy_r),
    .ctr_z (fz_r),
    .r2s   (r2s),
    .value (blk_r),
    .done  (scan_done),
    .we    (scan_we),
    .waddr (scan_waddr),
    .wdata (scan_wdata)
  );

  vcsf_store #(
    .AW(AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

endmodule

// ===== hw/rtl/vcsf_store.sv =====
// voxel memory: one write port and one read port with registered read data
// depends on vcsf_pkg
module vcsf_store #(
  parameter int AW = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [vcsf_pkg::VAL_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [vcsf_pkg::VAL_W-1:0] rdata
);
  import vcsf_pkg::*;

  logic [VAL_W-1:0] mem [0:(1<<AW)-1];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/vcsf_scan.sv =====
// box scanner: walks x, y, z over a box, one voxel per cycle, and issues a memory write
// for each voxel, in sphere mode only for a voxel inside the sphere; depends on vcsf_pkg
module vcsf_scan #(
  parameter int XW = 4,
  parameter int YW = 4,
  parameter int ZW = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vcsf_pkg::scan_ctl_t               ctl,
  input  logic [XW-1:0]                     lo_x,
  input  logic [XW-1:0]                     hi_x,
  input  logic [YW-1:0]                     lo_y,
  input  logic [YW-1:0]                     hi_y,
  input  logic [ZW-1:0]                     lo_z,
  input  logic [ZW-1:0]                     hi_z,
  input  logic signed [vcsf_pkg::CRD_W-1:0] ctr_x,
  input  logic signed [vcsf_pkg::CRD_W-1:0] ctr_y,
  input  logic signed [vcsf_pkg::CRD_W-1:0] ctr_z,
  input  logic [vcsf_pkg::R2S_W-1:0]        r2s,
  input  logic [vcsf_pkg::VAL_W-1:0]        value,
  output logic                              done,
  output logic                              we,
  output logic [XW+YW+ZW-1:0]               waddr,
  output logic [vcsf_pkg::VAL_W-1:0]        wdata
);
  import vcsf_pkg::*;

  localparam int AW = XW + YW + ZW;

  // stage a: coordinate counter
  logic              run_r, run_nxt;
  logic [XW-1:0]     i_r, i_nxt;
  logic [YW-1:0]     j_r, j_nxt;
  logic [ZW-1:0]     k_r, k_nxt;
  logic [XW-1:0]     hix_r;
  logic [YW-1:0]     loy_r, hiy_r;
  logic [ZW-1:0]     loz_r, hiz_r;
  logic signed [CRD_W-1:0] cx_r, cy_r, cz_r;
  logic [R2S_W-1:0]  r2s_r;
  logic [VAL_W-1:0]  value_r;
  logic              sphere_r;
  logic              last_a;

  // stage b: squares of the deltas
  logic              vb_r;
  logic              lastb_r;
  logic [AW-1:0]     addrb_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r, sqz_r;

  logic signed [DLT_W-1:0]   dx, dy, dz;
  logic signed [2*DLT_W-1:0] px, py, pz;
  logic [D2_W-1:0]           d2;

  assign last_a = (i_r == hix_r) && (j_r == hiy_r) && (k_r == hiz_r);

  always_comb begin
    run_nxt = run_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    if (ctl.start) begin
      run_nxt = 1'b1;
      i_nxt   = lo_x;
      j_nxt   = lo_y;
      k_nxt   = lo_z;
    end else if (run_r) begin
      if (last_a) begin
        run_nxt = 1'b0;
      end
      if (k_r == hiz_r) begin
        k_nxt = loz_r;
        if (j_r == hiy_r) begin
          j_nxt = loy_r;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    if (ctl.start) begin
      hix_r    <= hi_x;
      loy_r    <= lo_y;
      hiy_r    <= hi_y;
      loz_r    <= lo_z;
      hiz_r    <= hi_z;
      cx_r     <= ctr_x;
      cy_r     <= ctr_y;
      cz_r     <= ctr_z;
      r2s_r    <= r2s;
      value_r  <= value;
      sphere_r <= ctl.sphere;
    end
  end

  assign dx = $signed({{(DLT_W-XW){1'b0}}, i_r}) - $signed({cx_r[CRD_W-1], cx_r});
  assign dy = $signed({{(DLT_W-YW){1'b0}}, j_r}) - $signed({cy_r[CRD_W-1], cy_r});
  assign dz = $signed({{(DLT_W-ZW){1'b0}}, k_r}) - $signed({cz_r[CRD_W-1], cz_r});
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r    <= 1'b0;
      lastb_r <= 1'b0;
    end else begin
      vb_r    <= run_r;
      lastb_r <= run_r && last_a;
    end
  end

  always_ff @(posedge clk) begin
    addrb_r <= {i_r, j_r, k_r};
    sqx_r   <= px[SQ_W-1:0];
    sqy_r   <= py[SQ_W-1:0];
    sqz_r   <= pz[SQ_W-1:0];
  end

  assign d2 = {{(D2_W-SQ_W){1'b0}}, sqx_r} + {{(D2_W-SQ_W){1'b0}}, sqy_r}
            + {{(D2_W-SQ_W){1'b0}}, sqz_r};

  assign we    = vb_r && (!sphere_r || (d2 <= {{(D2_W-R2S_W){1'b0}}, r2s_r}));
  assign waddr = addrb_r;
  assign wdata = value_r;
  assign done  = vb_r && lastb_r;

endmodule

// ===== hw/rtl/vcsf_checker.sv =====
// port-level checks of the voxel cuboid and sphere fill block, bound to the top level
// depends on vcsf_pkg and voxel_cuboid_sphere_fill
module vcsf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [vcsf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import vcsf_pkg::*;

  // words taken in and not yet delivered
  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed or dropped");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result word without a pending command");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 |-> !in_tready)
    else $error("command taken while one is in work and one waits at the output");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[VAL_W] || (out_tdata[VAL_W-1:0] == '0))
    else $error("nonzero read value without a hit");

endmodule

bind voxel_cuboid_sphere_fill vcsf_checker u_vcsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/tb_voxel_cuboid_sphere_fill.sv =====
// testbench for voxel_cuboid_sphere_fill: random and directed place, fill and read words
// checked against a voxel mirror kept here; depends on vcsf_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_voxel_cuboid_sphere_fill;
  import vcsf_pkg::*;

  localparam int MAX_X = DEF_MAX_SIZE_X;
  localparam int MAX_Y = DEF_MAX_SIZE_Y;
  localparam int MAX_Z = DEF_MAX_SIZE_Z;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam longint LIMIT_NS = 64'd30_000_000;

  typedef struct packed {
    cmd_t             cmd;
    logic [CRD_W-1:0] fx, fy, fz;
    logic [CRD_W-1:0] sx, sy, sz;
    logic [RAD_W-1:0] radius;
    logic [VAL_W-1:0] value;
  } voxel_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             read_hit;
  } read_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  voxel_cuboid_sphere_fill u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // voxel mirror and size registers as the block should hold them
  logic [VAL_W-1:0] voxel_mirror [0:MAX_X-1][0:MAX_Y-1][0:MAX_Z-1];
  logic [SIZE_W-1:0] size_x_reg = SIZE_RESET;
  logic [SIZE_W-1:0] size_y_reg = SIZE_RESET;
  logic [SIZE_W-1:0] size_z_reg = SIZE_RESET;

  voxel_cmd_t   pending_cmds [$];
  read_result_t expected_reads [$];
  voxel_cmd_t   cur_cmd;

  int  errors = 0;
  int  cmds_sent = 0;
  int  results_checked = 0;
  int  read_hits = 0;
  int  cmd_count [4];
  int  send_gap = 0;
  int  rx_wait;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  function automatic int eff_dim(input logic [SIZE_W-1:0] r, input int lim);
    return (int'(r) > lim) ? lim : int'(r);
  endfunction

  function automatic int clamp_coord(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic read_result_t apply_to_mirror(input voxel_cmd_t c);
    int dx, dy, dz, x0, y0, z0, x1, y1, z1;
    int lx, hx, ly, hy, lz, hz, i, j, k;
    longint rad, d2;
    bit in_range;
    read_result_t res;
    dx = eff_dim(size_x_reg, MAX_X);
    dy = eff_dim(size_y_reg, MAX_Y);
    dz = eff_dim(size_z_reg, MAX_Z);
    x0 = int'($signed(c.fx));
    y0 = int'($signed(c.fy));
    z0 = int'($signed(c.fz));
    x1 = int'($signed(c.sx));
    y1 = int'($signed(c.sy));
    z1 = int'($signed(c.sz));
    rad = longint'($signed(c.radius));
    res = '0;
    in_range = x0 >= 0 && x0 < dx && y0 >= 0 && y0 < dy && z0 >= 0 && z0 < dz;
    case (c.cmd)
      CMD_PLACE: begin
        if (in_range) voxel_mirror[x0][y0][z0] = c.value;
      end
      CMD_CUBOID: begin
        if (dx > 0 && dy > 0 && dz > 0) begin
          x0 = clamp_coord(x0, dx - 1);
          x1 = clamp_coord(x1, dx - 1);
          y0 = clamp_coord(y0, dy - 1);
          y1 = clamp_coord(y1, dy - 1);
          z0 = clamp_coord(z0, dz - 1);
          z1 = clamp_coord(z1, dz - 1);
          lx = (x0 < x1) ? x0 : x1;
          hx = (x0 < x1) ? x1 : x0;
          ly = (y0 < y1) ? y0 : y1;
          hy = (y0 < y1) ? y1 : y0;
          lz = (z0 < z1) ? z0 : z1;
          hz = (z0 < z1) ? z1 : z0;
          for (i = lx; i <= hx; i++)
            for (j = ly; j <= hy; j++)
              for (k = lz; k <= hz; k++)
                voxel_mirror[i][j][k] = c.value;
        end
      end
      CMD_SPHERE: begin
        if (rad >= 0) begin
          for (i = 0; i < dx; i++)
            for (j = 0; j < dy; j++)
              for (k = 0; k < dz; k++) begin
                d2 = longint'(i - x0) * (i - x0) + longint'(j - y0) * (j - y0)
                   + longint'(k - z0) * (k - z0);
                if (d2 * 256 <= rad * rad) voxel_mirror[i][j][k] = c.value;
              end
        end
      end
      default: begin
        if (in_range) begin
          res.read_value = voxel_mirror[x0][y0][z0];
          res.read_hit = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_cmd(input voxel_cmd_t c);
    return {7'd0, c.value, c.radius, c.sz, c.sy, c.sx, c.fz, c.fy, c.fx};
  endfunction

  // sender: one word per handshake, random gap before each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (in_tvalid && !in_tready) begin
      in_tvalid <= 1'b1;
    end else begin
      if (in_tvalid) begin
        expected_reads.push_back(apply_to_mirror(cur_cmd));
        cmds_sent++;
        cmd_count[cur_cmd.cmd]++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        in_tdata <= pack_cmd(cur_cmd);
        in_tuser <= cur_cmd.cmd;
        in_tvalid <= 1'b1;
        send_gap <= gaps_on ? int'($urandom_range(0, 7)) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: checks each result word, random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      rx_wait = stall_left;
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (expected_reads.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, actual %h", $time, out_tdata);
        end else begin
          read_result_t e;
          e = expected_reads.pop_front();
          if (out_tdata[7:0] !== e.read_value) begin
            errors++;
            $display("%0t: read_value mismatch, expected %h actual %h",
                     $time, e.read_value, out_tdata[7:0]);
          end
          if (out_tdata[8] !== e.read_hit) begin
            errors++;
            $display("%0t: read_hit mismatch, expected %b actual %b",
                     $time, e.read_hit, out_tdata[8]);
          end
          if (e.read_hit) read_hits++;
        end
        rx_wait = gaps_on ? int'($urandom_range(0, 7)) : 0;
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        stall_left <= rx_wait;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        stall_left <= rx_wait;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        stall_left <= rx_wait - 1;
        out_tready <= 1'b0;
      end else begin
        stall_left <= 0;
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SIZE_X: size_x_reg = val;
      REG_SIZE_Y: size_y_reg = val;
      REG_SIZE_Z: size_z_reg = val;
      default: ;
    endcase
  endtask

  // sampled away from the rising edge so sender and receiver updates have settled
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_tvalid || expected_reads.size() != 0)
      @(negedge clk);
  endtask

  function automatic voxel_cmd_t make_cmd(input cmd_t op,
                                          input int x0, input int y0, input int z0,
                                          input int x1, input int y1, input int z1,
                                          input int rad, input int val);
    voxel_cmd_t c;
    c.cmd = op;
    c.fx = CRD_W'(x0);
    c.fy = CRD_W'(y0);
    c.fz = CRD_W'(z0);
    c.sx = CRD_W'(x1);
    c.sy = CRD_W'(y1);
    c.sz = CRD_W'(z1);
    c.radius = RAD_W'(rad);
    c.value = VAL_W'(val);
    return c;
  endfunction

  function automatic logic [CRD_W-1:0] pick_coord(input int dim);
    logic [CRD_W-1:0] v;
    if ($urandom_range(0, 9) < 7) v = CRD_W'($urandom_range(0, dim + 1) - 1);
    else v = CRD_W'($urandom);
    return v;
  endfunction

  function automatic voxel_cmd_t random_cmd();
    int dx, dy, dz, w, big;
    voxel_cmd_t c;
    dx = eff_dim(size_x_reg, MAX_X);
    dy = eff_dim(size_y_reg, MAX_Y);
    dz = eff_dim(size_z_reg, MAX_Z);
    big = dx > dy ? dx : dy;
    big = big > dz ? big : dz;
    w = $urandom_range(0, 99);
    if (w < 30) c.cmd = CMD_PLACE;
    else if (w < 50) c.cmd = CMD_CUBOID;
    else if (w < 65) c.cmd = CMD_SPHERE;
    else c.cmd = CMD_READ;
    c.fx = pick_coord(dx);
    c.fy = pick_coord(dy);
    c.fz = pick_coord(dz);
    c.sx = pick_coord(dx);
    c.sy = pick_coord(dy);
    c.sz = pick_coord(dz);
    if ($urandom_range(0, 7) == 0) c.radius = RAD_W'($urandom);
    else c.radius = RAD_W'($urandom_range(0, 16 * (big + 2)));
    c.value = VAL_W'($urandom);
    return c;
  endfunction

  task automatic run_phase(input logic [SIZE_W-1:0] nx, input logic [SIZE_W-1:0] ny,
                           input logic [SIZE_W-1:0] nz, input int count,
                           input bit with_gaps, input bit with_hold);
    write_size_reg(REG_SIZE_X, nx);
    write_size_reg(REG_SIZE_Y, ny);
    write_size_reg(REG_SIZE_Z, nz);
    gaps_on = with_gaps;
    repeat (count) pending_cmds.push_back(random_cmd());
    if (with_hold) begin
      @(posedge clk);
      hold_req <= 1'b1;
    end
    wait_drained();
  endtask

  initial begin
    foreach (voxel_mirror[i, j, k]) voxel_mirror[i][j][k] = '0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at full size
    write_size_reg(REG_SIZE_X, 5'd16);
    write_size_reg(REG_SIZE_Y, 5'd16);
    write_size_reg(REG_SIZE_Z, 5'd16);
    pending_cmds.push_back(make_cmd(CMD_PLACE, 0, 0, 0, 0, 0, 0, 0, 8'hFF));
    pending_cmds.push_back(make_cmd(CMD_PLACE, 15, 15, 15, 0, 0, 0, 0, 8'hA5));
    pending_cmds.push_back(make_cmd(CMD_PLACE, -1, 0, 0, 0, 0, 0, 0, 8'h11));
    pending_cmds.push_back(make_cmd(CMD_PLACE, 16, 3, 3, 0, 0, 0, 0, 8'h22));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 15, 15, 15, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, -512, 511, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 511, -512, -1, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CUBOID, -512, -512, -512, 511, 511, 511, 0, 8'h01));
    pending_cmds.push_back(make_cmd(CMD_CUBOID, 10, 12, 3, 2, 4, 9, 0, 8'h7E));
    pending_cmds.push_back(make_cmd(CMD_CUBOID, 5, 5, 5, 5, 5, 5, 0, 8'h80));
    pending_cmds.push_back(make_cmd(CMD_SPHERE, 8, 8, 8, 0, 0, 0, 0, 8'h33));
    pending_cmds.push_back(make_cmd(CMD_READ, 8, 8, 8, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 8, 8, 9, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_SPHERE, 8, 8, 8, 0, 0, 0, 4095, 8'h44));
    pending_cmds.push_back(make_cmd(CMD_SPHERE, 4, 4, 4, 0, 0, 0, -4096, 8'h55));
    pending_cmds.push_back(make_cmd(CMD_SPHERE, 4, 4, 4, 0, 0, 0, -1, 8'h56));
    pending_cmds.push_back(make_cmd(CMD_SPHERE, 3, 4, 5, 0, 0, 0, 56, 8'h66));
    pending_cmds.push_back(make_cmd(CMD_SPHERE, -5, 20, 7, 0, 0, 0, 160, 8'h77));
    pending_cmds.push_back(make_cmd(CMD_READ, 3, 4, 5, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 6, 5, 5, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 15, 9, 0, 0, 0, 0, 0));
    wait_drained();

    // random phases over several size settings
    run_phase(5'd4, 5'd5, 5'd3, 20, 1'b1, 1'b0);
    run_phase(5'd1, 5'd1, 5'd1, 15, 1'b0, 1'b0);
    run_phase(5'd0, 5'd7, 5'd7, 10, 1'b1, 1'b0);
    run_phase(5'd31, 5'd2, 5'd17, 25, 1'b1, 1'b1);
    write_size_reg(REG_UNUSED, 5'd5);
    run_phase(5'd6, 5'd6, 5'd6, 25, 1'b0, 1'b0);
    run_phase(5'd16, 5'd16, 5'd16, 15, 1'b1, 1'b0);
    run_phase(5'd3, 5'd16, 5'd2, 20, 1'b1, 1'b0);
    run_phase(5'd7, 5'd0, 5'd9, 5, 1'b1, 1'b0);
    repeat (20) @(posedge clk);

    $display("covered %0d words: %0d place, %0d cuboid, %0d sphere, %0d read",
             cmds_sent, cmd_count[CMD_PLACE], cmd_count[CMD_CUBOID],
             cmd_count[CMD_SPHERE], cmd_count[CMD_READ]);
    $display("%0d results checked, %0d read hits, %0d mismatches",
             results_checked, read_hits, errors);
    if (errors == 0 && expected_reads.size() == 0) begin
      $display("PASS voxel_cuboid_sphere_fill");
    end else begin
      $display("FAIL voxel_cuboid_sphere_fill");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", expected_reads.size());
    $display("FAIL voxel_cuboid_sphere_fill");
    $finish;
  end

endmodule
